// ===== rtl/udre_pkg.sv =====
// Shared types for the UART DMA ring buffer engine.
// This package has no dependencies. The controller and the testbench use it.
`default_nettype none

package udre_pkg;

    typedef enum logic [2:0] {
        FUNC_DMA  = 3'd0,
        FUNC_IDLE = 3'd1,
        FUNC_TXW  = 3'd2,
        FUNC_TXE  = 3'd3,
        FUNC_RXR  = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/udre_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// This module has no dependencies.
`default_nettype none

module udre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/udre_ctrl.sv =====
// Sequencer and ring pointers of the UART DMA ring buffer engine.
// It depends on udre_pkg and drives the three udre_ram instances of the top level.
`default_nettype none

module udre_ctrl #(
    parameter int LANDING_DEPTH = 256,
    parameter int RX_RING_DEPTH = 256,
    parameter int TX_RING_DEPTH = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    output logic                                  o_busy,
    input  wire logic [2:0]                       i_func,
    input  wire logic [7:0]                       i_byte_in,
    input  wire logic                             i_last_of_call,
    output logic                                  o_done,
    output logic      [7:0]                       o_rx_data,
    output logic                                  o_rx_valid,
    output logic      [7:0]                       o_line_data,
    output logic                                  o_line_valid,
    output logic                                  o_write_accepted,
    output logic      [7:0]                       o_rx_available,
    output logic                                  o_tx_request_enabled,
    output logic                                  o_land_we,
    output logic      [$clog2(LANDING_DEPTH)-1:0] o_land_waddr,
    output logic      [7:0]                       o_land_wdata,
    output logic                                  o_land_re,
    output logic      [$clog2(LANDING_DEPTH)-1:0] o_land_raddr,
    input  wire logic [7:0]                       i_land_rdata,
    output logic                                  o_rx_we,
    output logic      [$clog2(RX_RING_DEPTH)-1:0] o_rx_waddr,
    output logic      [7:0]                       o_rx_wdata,
    output logic                                  o_rx_re,
    output logic      [$clog2(RX_RING_DEPTH)-1:0] o_rx_raddr,
    input  wire logic [7:0]                       i_rx_rdata,
    output logic                                  o_tx_we,
    output logic      [$clog2(TX_RING_DEPTH)-1:0] o_tx_waddr,
    output logic      [7:0]                       o_tx_wdata,
    output logic                                  o_tx_re,
    output logic      [$clog2(TX_RING_DEPTH)-1:0] o_tx_raddr,
    input  wire logic [7:0]                       i_tx_rdata
);

    import udre_pkg::*;

    localparam int LAW = $clog2(LANDING_DEPTH);
    localparam int RAW = $clog2(RX_RING_DEPTH);
    localparam int TAW = $clog2(TX_RING_DEPTH);

    t_state r_state, n_state;

    logic [2:0]     r_func;
    logic [7:0]     r_byte;
    logic           r_last;
    logic [LAW-1:0] r_lwp, n_lwp, r_lrp, n_lrp;
    logic [RAW-1:0] r_rh, n_rh, r_rt, n_rt;
    logic [TAW-1:0] r_th, n_th, r_tt, n_tt;
    logic           r_ten, n_ten;
    logic           r_rx_valid, n_rx_valid;
    logic           r_line_valid, n_line_valid;
    logic           r_acc, n_acc;

    logic [LAW-1:0] lwp_inc, lrp_inc;
    logic [RAW-1:0] rh_inc, rt_inc;
    logic [TAW-1:0] th_inc, tt_inc;
    logic [RAW:0]   rx_cnt;

    assign lwp_inc = (r_lwp == LAW'(LANDING_DEPTH - 1)) ? '0 : r_lwp + 1'b1;
    assign lrp_inc = (r_lrp == LAW'(LANDING_DEPTH - 1)) ? '0 : r_lrp + 1'b1;
    assign rh_inc  = (r_rh == RAW'(RX_RING_DEPTH - 1)) ? '0 : r_rh + 1'b1;
    assign rt_inc  = (r_rt == RAW'(RX_RING_DEPTH - 1)) ? '0 : r_rt + 1'b1;
    assign th_inc  = (r_th == TAW'(TX_RING_DEPTH - 1)) ? '0 : r_th + 1'b1;
    assign tt_inc  = (r_tt == TAW'(TX_RING_DEPTH - 1)) ? '0 : r_tt + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_func == FUNC_IDLE && r_lrp != r_lwp) begin
                    n_state = ST_MOVE_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MOVE_RD: n_state = ST_MOVE_WR;
            ST_MOVE_WR: begin
                if (r_lrp != r_lwp) begin
                    n_state = ST_MOVE_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_lwp        = r_lwp;
        n_lrp        = r_lrp;
        n_rh         = r_rh;
        n_rt         = r_rt;
        n_th         = r_th;
        n_tt         = r_tt;
        n_ten        = r_ten;
        n_rx_valid   = r_rx_valid;
        n_line_valid = r_line_valid;
        n_acc        = r_acc;
        o_land_we    = 1'b0;
        o_land_waddr = r_lwp;
        o_land_wdata = r_byte;
        o_land_re    = 1'b0;
        o_land_raddr = r_lrp;
        o_rx_we      = 1'b0;
        o_rx_waddr   = r_rh;
        o_rx_wdata   = i_land_rdata;
        o_rx_re      = 1'b0;
        o_rx_raddr   = r_rt;
        o_tx_we      = 1'b0;
        o_tx_waddr   = r_th;
        o_tx_wdata   = r_byte;
        o_tx_re      = 1'b0;
        o_tx_raddr   = r_tt;
        case (r_state)
            ST_IDLE: begin
                n_rx_valid   = 1'b0;
                n_line_valid = 1'b0;
                n_acc        = 1'b0;
            end
            ST_EXEC: begin
                case (r_func)
                    FUNC_DMA: begin
                        o_land_we = 1'b1;
                        n_lwp     = lwp_inc;
                    end
                    FUNC_TXW: begin
                        if (th_inc != r_tt) begin
                            o_tx_we = 1'b1;
                            n_th    = th_inc;
                            n_acc   = 1'b1;
                        end
                        if (r_last && ((th_inc != r_tt) || (r_th != r_tt))) begin
                            n_ten = 1'b1;
                        end
                    end
                    FUNC_TXE: begin
                        if (r_ten) begin
                            if (r_th != r_tt) begin
                                o_tx_re      = 1'b1;
                                n_tt         = tt_inc;
                                n_line_valid = 1'b1;
                            end else begin
                                n_ten = 1'b0;
                            end
                        end
                    end
                    FUNC_RXR: begin
                        if (r_rh != r_rt) begin
                            o_rx_re    = 1'b1;
                            n_rt       = rt_inc;
                            n_rx_valid = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_MOVE_RD: begin
                o_land_re = 1'b1;
                n_lrp     = lrp_inc;
            end
            ST_MOVE_WR: begin
                if (rh_inc != r_rt) begin
                    o_rx_we = 1'b1;
                    n_rh    = rh_inc;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_lwp        <= '0;
            r_lrp        <= '0;
            r_rh         <= '0;
            r_rt         <= '0;
            r_th         <= '0;
            r_tt         <= '0;
            r_ten        <= 1'b0;
            r_rx_valid   <= 1'b0;
            r_line_valid <= 1'b0;
            r_acc        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_lwp        <= n_lwp;
            r_lrp        <= n_lrp;
            r_rh         <= n_rh;
            r_rt         <= n_rt;
            r_th         <= n_th;
            r_tt         <= n_tt;
            r_ten        <= n_ten;
            r_rx_valid   <= n_rx_valid;
            r_line_valid <= n_line_valid;
            r_acc        <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_func <= i_func;
            r_byte <= i_byte_in;
            r_last <= i_last_of_call;
        end
    end

    always_comb begin
        if (r_rh >= r_rt) begin
            rx_cnt = {1'b0, r_rh} - {1'b0, r_rt};
        end else begin
            rx_cnt = (RAW + 1)'(RX_RING_DEPTH) - {1'b0, r_rt} + {1'b0, r_rh};
        end
    end

    always_comb begin
        o_busy               = (r_state != ST_IDLE);
        o_done               = (r_state == ST_DONE);
        o_rx_valid           = o_done && r_rx_valid;
        o_rx_data            = o_rx_valid ? i_rx_rdata : 8'h00;
        o_line_valid         = o_done && r_line_valid;
        o_line_data          = o_line_valid ? i_tx_rdata : 8'h00;
        o_write_accepted     = o_done && r_acc;
        o_tx_request_enabled = r_ten;
        if (32'(rx_cnt) > 32'd255) begin
            o_rx_available = 8'hFF;
        end else begin
            o_rx_available = 8'(rx_cnt);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uart_dma_ring_buffer_engine.sv =====
// Top level of the UART DMA ring buffer engine: a sequencer and three RAMs.
// It depends on udre_pkg, udre_ram and udre_ctrl.
// A request is carried out in the execute state and its results are shown in the done state;
// a line idle request passes through a landing RAM read state and a ring write state for each
// landing byte, writing the ring only when it has room. A new request is taken only when idle.
// Reset (synchronous, active low) clears all positions and the transmit enable; the
// RAM contents are not cleared. Results are shown for one cycle and cannot be stalled.
`default_nettype none

module uart_dma_ring_buffer_engine #(
    parameter int LANDING_DEPTH = 256,
    parameter int RX_RING_DEPTH = 256,
    parameter int TX_RING_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire logic [2:0] i_func,
    input  wire logic [7:0] i_byte_in,
    input  wire logic       i_last_of_call,
    output logic            o_done,
    output logic      [7:0] o_rx_data,
    output logic            o_rx_valid,
    output logic      [7:0] o_line_data,
    output logic            o_line_valid,
    output logic            o_write_accepted,
    output logic      [7:0] o_rx_available,
    output logic            o_tx_request_enabled
);

    localparam int LAW = $clog2(LANDING_DEPTH);
    localparam int RAW = $clog2(RX_RING_DEPTH);
    localparam int TAW = $clog2(TX_RING_DEPTH);

    logic           land_we, land_re, rx_we, rx_re, tx_we, tx_re;
    logic [LAW-1:0] land_waddr, land_raddr;
    logic [RAW-1:0] rx_waddr, rx_raddr;
    logic [TAW-1:0] tx_waddr, tx_raddr;
    logic [7:0]     land_wdata, land_rdata, rx_wdata, rx_rdata, tx_wdata, tx_rdata;

    udre_ctrl #(
        .LANDING_DEPTH(LANDING_DEPTH),
        .RX_RING_DEPTH(RX_RING_DEPTH),
        .TX_RING_DEPTH(TX_RING_DEPTH)
    ) u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_func              (i_func),
        .i_byte_in           (i_byte_in),
        .i_last_of_call      (i_last_of_call),
        .o_done              (o_done),
        .o_rx_data           (o_rx_data),
        .o_rx_valid          (o_rx_valid),
        .o_line_data         (o_line_data),
        .o_line_valid        (o_line_valid),
        .o_write_accepted    (o_write_accepted),
        .o_rx_available      (o_rx_available),
        .o_tx_request_enabled(o_tx_request_enabled),
        .o_land_we           (land_we),
        .o_land_waddr        (land_waddr),
        .o_land_wdata        (land_wdata),
        .o_land_re           (land_re),
        .o_land_raddr        (land_raddr),
        .i_land_rdata        (land_rdata),
        .o_rx_we             (rx_we),
        .o_rx_waddr          (rx_waddr),
        .o_rx_wdata          (rx_wdata),
        .o_rx_re             (rx_re),
        .o_rx_raddr          (rx_raddr),
        .i_rx_rdata          (rx_rdata),
        .o_tx_we             (tx_we),
        .o_tx_waddr          (tx_waddr),
        .o_tx_wdata          (tx_wdata),
        .o_tx_re             (tx_re),
        .o_tx_raddr          (tx_raddr),
        .i_tx_rdata          (tx_rdata)
    );

    udre_ram #(.WIDTH(8), .DEPTH(LANDING_DEPTH)) u_land_ram (
        .i_clk  (i_clk),
        .i_we   (land_we),
        .i_waddr(land_waddr),
        .i_wdata(land_wdata),
        .i_re   (land_re),
        .i_raddr(land_raddr),
        .o_rdata(land_rdata)
    );

    udre_ram #(.WIDTH(8), .DEPTH(RX_RING_DEPTH)) u_rx_ram (
        .i_clk  (i_clk),
        .i_we   (rx_we),
        .i_waddr(rx_waddr),
        .i_wdata(rx_wdata),
        .i_re   (rx_re),
        .i_raddr(rx_raddr),
        .o_rdata(rx_rdata)
    );

    udre_ram #(.WIDTH(8), .DEPTH(TX_RING_DEPTH)) u_tx_ram (
        .i_clk  (i_clk),
        .i_we   (tx_we),
        .i_waddr(tx_waddr),
        .i_wdata(tx_wdata),
        .i_re   (tx_re),
        .i_raddr(tx_raddr),
        .o_rdata(tx_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/udre_chk.sv =====
// Port-level checker for the UART DMA ring buffer engine, bound to the top level.
// It depends on uart_dma_ring_buffer_engine.
`default_nettype none

module udre_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       o_busy,
    input wire logic       o_done,
    input wire logic       o_rx_valid,
    input wire logic       o_line_valid,
    input wire logic       o_write_accepted,
    input wire logic [7:0] o_rx_data,
    input wire logic [7:0] o_line_data
);

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_done))
        else $error("taken request did not make the block busy");

    a_flags_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rx_valid || o_line_valid || o_write_accepted) |->
        (o_done && $countones({o_rx_valid, o_line_valid, o_write_accepted}) == 1))
        else $error("result flag outside a single result");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((!o_rx_valid) |-> (o_rx_data == 8'h00)) and
        ((!o_line_valid) |-> (o_line_data == 8'h00)))
        else $error("data byte shown without its valid flag");

endmodule

bind uart_dma_ring_buffer_engine udre_chk u_udre_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_done          (o_done),
    .o_rx_valid      (o_rx_valid),
    .o_line_valid    (o_line_valid),
    .o_write_accepted(o_write_accepted),
    .o_rx_data       (o_rx_data),
    .o_line_data     (o_line_data)
);

`default_nettype wire

// ===== sim/uart_dma_ring_buffer_engine_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the UART DMA ring buffer engine: directed corner cases, ring fill
// and landing wrap sequences, then random request mixes, each result checked against a model.
// It depends on udre_pkg and the uart_dma_ring_buffer_engine top level.

module uart_dma_ring_buffer_engine_test;
    import udre_pkg::*;

    localparam logic [2:0] FUNC_SPARE5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_REQS = 150;
    localparam int CALM_REQS = 50;
    localparam int OVERFLOW_READS = 64;

    typedef struct packed {
        logic [7:0] rx_data;
        logic       rx_valid;
        logic [7:0] line_data;
        logic       line_valid;
        logic       write_accepted;
        logic [7:0] rx_available;
        logic       tx_request_enabled;
    } t_outcome;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    logic [2:0] i_func;
    logic [7:0] i_byte_in;
    logic       i_last_of_call;
    logic       o_done;
    logic [7:0] o_rx_data;
    logic       o_rx_valid;
    logic [7:0] o_line_data;
    logic       o_line_valid;
    logic       o_write_accepted;
    logic [7:0] o_rx_available;
    logic       o_tx_request_enabled;

    logic [7:0] land_mem [256];
    logic [7:0] rx_mem [256];
    logic [7:0] tx_mem [256];
    logic [7:0] land_wr, land_rd, rx_hd, rx_tl, tx_hd, tx_tl;
    logic       tx_en;

    t_outcome outcome_q [$];
    t_outcome seen, want;
    int       mismatches = 0;
    int       req_count = 0;
    int       stall_cycles = 0;
    bit       gaps_on = 1'b1;

    uart_dma_ring_buffer_engine u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (i_start),
        .o_busy               (o_busy),
        .i_func               (i_func),
        .i_byte_in            (i_byte_in),
        .i_last_of_call       (i_last_of_call),
        .o_done               (o_done),
        .o_rx_data            (o_rx_data),
        .o_rx_valid           (o_rx_valid),
        .o_line_data          (o_line_data),
        .o_line_valid         (o_line_valid),
        .o_write_accepted     (o_write_accepted),
        .o_rx_available       (o_rx_available),
        .o_tx_request_enabled (o_tx_request_enabled)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic clear_rings();
        for (int i = 0; i < 256; i++) begin
            land_mem[i] = 8'h00;
            rx_mem[i] = 8'h00;
            tx_mem[i] = 8'h00;
        end
        land_wr = '0;
        land_rd = '0;
        rx_hd = '0;
        rx_tl = '0;
        tx_hd = '0;
        tx_tl = '0;
        tx_en = 1'b0;
    endtask

    function automatic t_outcome ring_step(logic [2:0] f, logic [7:0] b, logic last);
        t_outcome r;
        logic [7:0] nxt;
        r = '0;
        case (f)
            FUNC_DMA: begin
                land_mem[land_wr] = b;
                land_wr = land_wr + 8'd1;
            end
            FUNC_IDLE: begin
                while (land_rd != land_wr) begin
                    nxt = rx_hd + 8'd1;
                    if (nxt != rx_tl) begin
                        rx_mem[rx_hd] = land_mem[land_rd];
                        rx_hd = nxt;
                    end
                    land_rd = land_rd + 8'd1;
                end
            end
            FUNC_TXW: begin
                nxt = tx_hd + 8'd1;
                if (nxt != tx_tl) begin
                    tx_mem[tx_hd] = b;
                    tx_hd = nxt;
                    r.write_accepted = 1'b1;
                end
                if (last && (tx_hd != tx_tl)) begin
                    tx_en = 1'b1;
                end
            end
            FUNC_TXE: begin
                if (tx_en) begin
                    if (tx_hd != tx_tl) begin
                        r.line_data = tx_mem[tx_tl];
                        r.line_valid = 1'b1;
                        tx_tl = tx_tl + 8'd1;
                    end else begin
                        tx_en = 1'b0;
                    end
                end
            end
            FUNC_RXR: begin
                if (rx_hd != rx_tl) begin
                    r.rx_data = rx_mem[rx_tl];
                    r.rx_valid = 1'b1;
                    rx_tl = rx_tl + 8'd1;
                end
            end
            default: begin
            end
        endcase
        r.rx_available = rx_hd - rx_tl;
        r.tx_request_enabled = tx_en;
        return r;
    endfunction

    function automatic string outcome_text(t_outcome r);
        return $sformatf("rx %h/%b line %h/%b acc %b avail %0d en %b", r.rx_data, r.rx_valid,
                         r.line_data, r.line_valid, r.write_accepted, r.rx_available,
                         r.tx_request_enabled);
    endfunction

    task automatic send_req(logic [2:0] f, logic [7:0] b, logic last);
        int gap;
        t_outcome r;
        if (gaps_on && ($urandom_range(0, 4) == 0)) begin
            gap = $urandom_range(1, 13);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_func <= f;
        i_byte_in <= b;
        i_last_of_call <= last;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        r = ring_step(f, b, last);
        outcome_q.push_back(r);
        req_count++;
    endtask

    task automatic test_directed();
        send_req(FUNC_RXR, 8'h00, 1'b0);
        send_req(FUNC_TXE, 8'h00, 1'b0);
        send_req(FUNC_TXW, 8'h00, 1'b0);
        send_req(FUNC_TXW, 8'hFF, 1'b1);
        send_req(FUNC_TXE, 8'hFF, 1'b1);
        send_req(FUNC_TXE, 8'h00, 1'b0);
        send_req(FUNC_TXE, 8'h00, 1'b0);
        send_req(FUNC_TXE, 8'h00, 1'b0);
        send_req(FUNC_DMA, 8'h00, 1'b0);
        send_req(FUNC_DMA, 8'hFF, 1'b1);
        send_req(FUNC_DMA, 8'hA5, 1'b0);
        send_req(FUNC_IDLE, 8'hFF, 1'b1);
        send_req(FUNC_IDLE, 8'h00, 1'b0);
        send_req(FUNC_RXR, 8'hFF, 1'b1);
        send_req(FUNC_RXR, 8'h00, 1'b0);
        send_req(FUNC_RXR, 8'h00, 1'b0);
        send_req(FUNC_RXR, 8'h00, 1'b0);
        send_req(FUNC_SPARE5, 8'hFF, 1'b1);
        send_req(FUNC_SPARE6, 8'h5A, 1'b0);
        send_req(FUNC_SPARE7, 8'hFF, 1'b1);
    endtask

    task automatic test_tx_ring_full();
        for (int i = 0; i < 256; i++) begin
            send_req(FUNC_TXW, 8'($urandom), (i == 255));
        end
        for (int i = 0; i < 257; i++) begin
            send_req(FUNC_TXE, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_landing_wrap();
        for (int i = 0; i < 256; i++) begin
            send_req(FUNC_DMA, 8'($urandom), 1'($urandom));
        end
        send_req(FUNC_IDLE, 8'h00, 1'b0);
        for (int i = 0; i < 3; i++) begin
            send_req(FUNC_DMA, 8'($urandom), 1'b0);
        end
        send_req(FUNC_IDLE, 8'h00, 1'b0);
        for (int i = 0; i < 4; i++) begin
            send_req(FUNC_RXR, 8'h00, (i == 3));
        end
    endtask

    task automatic test_rx_overflow();
        for (int i = 0; i < 140; i++) begin
            send_req(FUNC_DMA, 8'($urandom), 1'b0);
        end
        send_req(FUNC_IDLE, 8'h00, 1'b0);
        for (int i = 0; i < 120; i++) begin
            send_req(FUNC_DMA, 8'($urandom), 1'b0);
        end
        send_req(FUNC_IDLE, 8'h00, 1'b0);
        for (int i = 0; i < OVERFLOW_READS; i++) begin
            send_req(FUNC_RXR, 8'($urandom), (i == OVERFLOW_READS - 1));
        end
    endtask

    task automatic test_random_mix();
        int first, n, m;
        bit closed;
        first = req_count;
        while (req_count - first < RANDOM_REQS) begin
            gaps_on = (req_count - first < RANDOM_REQS - CALM_REQS);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = ($urandom_range(0, 24) == 0) ? $urandom_range(40, 255)
                                                     : $urandom_range(1, 24);
                    for (int i = 0; i < n; i++) begin
                        send_req(FUNC_DMA, 8'($urandom), 1'($urandom));
                    end
                    send_req(FUNC_IDLE, 8'($urandom), 1'($urandom));
                end
                3, 4: begin
                    n = $urandom_range(1, 30);
                    for (int i = 0; i < n; i++) begin
                        send_req(FUNC_RXR, 8'($urandom), (i == n - 1));
                    end
                end
                5, 6, 7: begin
                    n = $urandom_range(1, 30);
                    closed = ($urandom_range(0, 7) != 0);
                    for (int i = 0; i < n; i++) begin
                        send_req(FUNC_TXW, 8'($urandom), closed && (i == n - 1));
                    end
                    m = $urandom_range(1, n + 2);
                    for (int i = 0; i < m; i++) begin
                        send_req(FUNC_TXE, 8'($urandom), 1'($urandom));
                    end
                end
                8: begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++) begin
                        send_req(FUNC_SPARE5 + 3'($urandom_range(0, 2)), 8'($urandom),
                                 1'($urandom));
                    end
                end
                default: begin
                    n = $urandom_range(1, 10);
                    for (int i = 0; i < n; i++) begin
                        send_req(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
                    end
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            seen.rx_data = o_rx_data;
            seen.rx_valid = o_rx_valid;
            seen.line_data = o_line_data;
            seen.line_valid = o_line_valid;
            seen.write_accepted = o_write_accepted;
            seen.rx_available = o_rx_available;
            seen.tx_request_enabled = o_tx_request_enabled;
            if (outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unrequested result: %s", outcome_text(seen));
                end
            end else begin
                want = outcome_q.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected %s, got %s", outcome_text(want),
                                 outcome_text(seen));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_done) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("uart_dma_ring_buffer_engine_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_func <= FUNC_DMA;
        i_byte_in <= 8'h00;
        i_last_of_call <= 1'b0;
        clear_rings();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_tx_ring_full();
        test_landing_wrap();
        test_rx_overflow();
        test_random_mix();
        i_start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("uart_dma_ring_buffer_engine_test OK");
        end else begin
            $display("uart_dma_ring_buffer_engine_test NOT OK");
        end
        $finish;
    end

endmodule
